FILE: design/kfq_pkg.sv
// Package for the keyed FIFO queue: operation, status and state codes,
// and the beat types that the request and response channels carry.
// It depends on nothing.
`timescale 1ns / 1ps

package kfq_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_DONE      = 2'd1,
    ST_DONE_TAIL = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] car_id;
    logic [7:0]  car_dest;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  found_dest;
    logic [4:0]  entry_count;
  } rsp_t;

endpackage

FILE: design/kfq_if.sv
// Valid/ready channel interfaces for the keyed FIFO queue.
// They depend on the beat types of kfq_pkg.
`timescale 1ns / 1ps

interface kfq_req_if;
  logic          valid;
  logic          ready;
  kfq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kfq_rsp_if;
  logic          valid;
  logic          ready;
  kfq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/kfq_store.sv
// Entry store of the keyed FIFO queue: identifier and destination arrays
// with one write port and one registered read port. No dependencies.
`timescale 1ns / 1ps

module kfq_store #(
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [15:0]              wr_id_i,
  input  logic [7:0]               wr_dest_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [15:0]              rd_id_o,
  output logic [7:0]               rd_dest_o
);

  logic [15:0] ids_q   [DEPTH];
  logic [7:0]  dests_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ids_q[wr_addr_i]   <= wr_id_i;
      dests_q[wr_addr_i] <= wr_dest_i;
    end
    rd_id_o   <= ids_q[rd_addr_i];
    rd_dest_o <= dests_q[rd_addr_i];
  end

endmodule

FILE: design/keyed_fifo_queue.sv
// Top level of the keyed FIFO queue: sequencer, fill count and response register.
// It depends on kfq_pkg, the channel interfaces in kfq_if and kfq_store.
//
//   channel   direction   beat
//   req_i     in          operation, car_id, car_dest
//   rsp_o     out         status, found_dest, entry_count
//
// Append and clear go straight from acceptance to the done state.
// Find and remove scan the store through its single read port, one entry a
// cycle, until a match or the end of the filled entries.
// Remove then moves each later entry up one place at one entry a cycle.
// Reset clears the fill count and the control state; the store needs no clearing.
// A stalled response holds in its register while the next request is taken.
`timescale 1ns / 1ps

module keyed_fifo_queue #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kfq_req_if.sink    req_i,
  kfq_rsp_if.source  rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  kfq_pkg::state_e  state_q, state_d;
  kfq_pkg::op_e     op_q, op_d;
  logic [15:0]      key_q, key_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_idx_q, pend_idx_d;
  logic [CW-1:0]    src_q, src_d;
  logic             wpend_q, wpend_d;
  logic [AW-1:0]    wdst_q, wdst_d;
  kfq_pkg::status_e res_status_q, res_status_d;
  logic [7:0]       res_dest_q, res_dest_d;
  logic [CW-1:0]    res_count_q, res_count_d;
  logic             out_valid_q, out_valid_d;
  kfq_pkg::rsp_t    out_data_q, out_data_d;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [15:0]      wr_id;
  logic [7:0]       wr_dest;
  logic [AW-1:0]    rd_addr;
  logic [15:0]      rd_id;
  logic [7:0]       rd_dest;
  logic [CW-1:0]    pend_next;
  logic [CW-1:0]    src_dec;
  logic [CW+4:0]    count_ext;

  kfq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_id_i   (wr_id),
    .wr_dest_i (wr_dest),
    .rd_addr_i (rd_addr),
    .rd_id_o   (rd_id),
    .rd_dest_o (rd_dest)
  );

  assign req_i.ready = (state_q == kfq_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  assign pend_next = CW'(pend_idx_q) + OneC;
  assign src_dec   = src_q - OneC;
  assign count_ext = {5'b0, res_count_q};
  assign rd_addr   = (state_q == kfq_pkg::S_SCAN) ? idx_q[AW-1:0] : src_q[AW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    src_d        = src_q;
    wpend_d      = wpend_q;
    wdst_d       = wdst_q;
    res_status_d = res_status_q;
    res_dest_d   = res_dest_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    wr_en        = 1'b0;
    wr_addr      = fill_q[AW-1:0];
    wr_id        = req_i.data.car_id;
    wr_dest      = req_i.data.car_dest;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      kfq_pkg::S_IDLE: begin
        if (accept) begin
          op_d       = req_i.data.operation;
          key_d      = req_i.data.car_id;
          res_dest_d = 8'd0;
          idx_d      = '0;
          pend_d     = 1'b0;
          unique case (req_i.data.operation)
            kfq_pkg::OP_APPEND: begin
              if (fill_q >= DepthC) begin
                res_status_d = kfq_pkg::ST_FULL;
                res_count_d  = fill_q;
              end else begin
                wr_en        = 1'b1;
                fill_d       = fill_q + OneC;
                res_status_d = kfq_pkg::ST_DONE;
                res_count_d  = fill_q + OneC;
              end
              state_d = kfq_pkg::S_DONE;
            end
            kfq_pkg::OP_CLEAR: begin
              res_status_d = kfq_pkg::ST_DONE;
              res_count_d  = fill_q;
              fill_d       = '0;
              state_d      = kfq_pkg::S_DONE;
            end
            default: begin
              state_d = kfq_pkg::S_SCAN;
            end
          endcase
        end
      end

      kfq_pkg::S_SCAN: begin
        if (pend_q && (rd_id == key_q)) begin
          res_count_d = fill_q;
          if (op_q == kfq_pkg::OP_FIND) begin
            res_status_d = kfq_pkg::ST_DONE;
            res_dest_d   = rd_dest;
            state_d      = kfq_pkg::S_DONE;
          end else begin
            res_status_d = (pend_next == fill_q) ? kfq_pkg::ST_DONE_TAIL
                                                 : kfq_pkg::ST_DONE;
            src_d        = pend_next;
            wpend_d      = 1'b0;
            state_d      = kfq_pkg::S_SHIFT;
          end
        end else if (idx_q >= fill_q) begin
          res_status_d = kfq_pkg::ST_NOT_FOUND;
          res_count_d  = fill_q;
          pend_d       = 1'b0;
          state_d      = kfq_pkg::S_DONE;
        end else begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q[AW-1:0];
          idx_d      = idx_q + OneC;
        end
      end

      kfq_pkg::S_SHIFT: begin
        if (wpend_q) begin
          wr_en   = 1'b1;
          wr_addr = wdst_q;
          wr_id   = rd_id;
          wr_dest = rd_dest;
        end
        if (src_q < fill_q) begin
          wpend_d = 1'b1;
          wdst_d  = src_dec[AW-1:0];
          src_d   = src_q + OneC;
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            fill_d      = fill_q - OneC;
            res_count_d = fill_q - OneC;
            state_d     = kfq_pkg::S_DONE;
          end
        end
      end

      kfq_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = res_status_q;
          out_data_d.found_dest  = res_dest_q;
          out_data_d.entry_count = count_ext[4:0];
          state_d                = kfq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kfq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfq_pkg::S_IDLE;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pend_idx_q   <= pend_idx_d;
    src_q        <= src_d;
    wdst_q       <= wdst_d;
    res_status_q <= res_status_d;
    res_dest_q   <= res_dest_d;
    res_count_q  <= res_count_d;
    out_data_q   <= out_data_d;
  end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for keyed_fifo_queue: a table of directed beats, then random
// beats, each response checked against its table entry or an in-bench queue model.
// It depends on kfq_pkg, the channel interfaces in kfq_if and the keyed_fifo_queue RTL.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH          = 16;
  localparam int RANDOM_BEATS   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 4 * DEPTH + 20;

  typedef struct packed {
    kfq_pkg::op_e  op;
    logic [15:0]   id;
    logic [7:0]    dest;
    logic          typed;
    kfq_pkg::rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  kfq_req_if req_if ();
  kfq_rsp_if rsp_if ();

  keyed_fifo_queue #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [15:0]   shadow_ids [DEPTH];
  logic [7:0]    shadow_dests [DEPTH];
  int            shadow_fill = 0;
  kfq_pkg::rsp_t pending_rsp [$];
  int            err_cnt = 0;
  int            rx_count = 0;
  logic          quiet = 1'b0;

  dir_row_t dir_rows [18] = '{
    '{kfq_pkg::OP_FIND,   16'h0000, 8'h00, 1'b1, '{kfq_pkg::ST_NOT_FOUND, 8'h00, 5'd0}},
    '{kfq_pkg::OP_REMOVE, 16'h0000, 8'h00, 1'b1, '{kfq_pkg::ST_NOT_FOUND, 8'h00, 5'd0}},
    '{kfq_pkg::OP_CLEAR,  16'h0000, 8'h00, 1'b1, '{kfq_pkg::ST_DONE,      8'h00, 5'd0}},
    '{kfq_pkg::OP_APPEND, 16'h0000, 8'h00, 1'b1, '{kfq_pkg::ST_DONE,      8'h00, 5'd1}},
    '{kfq_pkg::OP_APPEND, 16'hFFFF, 8'hFF, 1'b1, '{kfq_pkg::ST_DONE,      8'h00, 5'd2}},
    '{kfq_pkg::OP_FIND,   16'hFFFF, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_FIND,   16'h0000, 8'hFF, 1'b0, '0},
    '{kfq_pkg::OP_FIND,   16'h5A5A, 8'h00, 1'b1, '{kfq_pkg::ST_NOT_FOUND, 8'h00, 5'd2}},
    '{kfq_pkg::OP_APPEND, 16'h1234, 8'h05, 1'b0, '0},
    '{kfq_pkg::OP_APPEND, 16'h1234, 8'h06, 1'b0, '0},
    '{kfq_pkg::OP_FIND,   16'h1234, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_REMOVE, 16'h1234, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_REMOVE, 16'h1234, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_REMOVE, 16'h5A5A, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_FIND,   16'h0000, 8'h00, 1'b0, '0},
    '{kfq_pkg::OP_APPEND, 16'h8000, 8'h80, 1'b0, '0},
    '{kfq_pkg::OP_CLEAR,  16'hFFFF, 8'hFF, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic kfq_pkg::rsp_t predict_response(kfq_pkg::req_t beat);
    kfq_pkg::rsp_t r;
    int            pos;
    int            count;
    r.status     = kfq_pkg::ST_NOT_FOUND;
    r.found_dest = '0;
    pos          = shadow_fill;
    for (int i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_ids[i] == beat.car_id) pos = i;
    end
    case (beat.operation)
      kfq_pkg::OP_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          r.status = kfq_pkg::ST_FULL;
        end else begin
          shadow_ids[shadow_fill]   = beat.car_id;
          shadow_dests[shadow_fill] = beat.car_dest;
          shadow_fill++;
          r.status = kfq_pkg::ST_DONE;
        end
        count = shadow_fill;
      end
      kfq_pkg::OP_FIND: begin
        if (pos < shadow_fill) begin
          r.status     = kfq_pkg::ST_DONE;
          r.found_dest = shadow_dests[pos];
        end
        count = shadow_fill;
      end
      kfq_pkg::OP_REMOVE: begin
        if (pos < shadow_fill) begin
          r.status = (pos == shadow_fill - 1) ? kfq_pkg::ST_DONE_TAIL : kfq_pkg::ST_DONE;
          for (int i = pos; i < shadow_fill - 1; i++) begin
            shadow_ids[i]   = shadow_ids[i + 1];
            shadow_dests[i] = shadow_dests[i + 1];
          end
          shadow_fill--;
        end
        count = shadow_fill;
      end
      default: begin
        count       = shadow_fill;
        shadow_fill = 0;
        r.status    = kfq_pkg::ST_DONE;
      end
    endcase
    r.entry_count = 5'(count);
    return r;
  endfunction

  task automatic send_beat(input kfq_pkg::req_t beat, input logic typed,
                           input kfq_pkg::rsp_t want);
    kfq_pkg::rsp_t predicted;
    if (!quiet && $urandom_range(99) < 15) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= beat;
    do @(posedge clk); while (!req_if.ready);
    predicted = predict_response(beat);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id(input kfq_pkg::op_e op);
    if (op != kfq_pkg::OP_APPEND && shadow_fill > 0 && $urandom_range(99) < 70)
      return shadow_ids[$urandom_range(shadow_fill - 1)];
    if ($urandom_range(99) < 60) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  function automatic void check_beat(input kfq_pkg::rsp_t got);
    kfq_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      $error("unexpected response beat: status %0d, found_dest %0d, entry_count %0d",
             got.status, got.found_dest, got.entry_count);
      err_cnt++;
      return;
    end
    want = pending_rsp.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_cnt++;
    end
    if (got.found_dest !== want.found_dest) begin
      $error("found_dest: expected %0d, got %0d", want.found_dest, got.found_dest);
      err_cnt++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      err_cnt++;
    end
  endfunction

  // Response side: random back-pressure, none while quiet, plus one long hold-off
  // so that the queue stalls its request channel.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        check_beat(rsp_if.data);
        rx_count++;
      end
      if (rx_count == HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_if.ready <= quiet || ($urandom_range(99) >= 15);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    kfq_pkg::req_t beat;
    int            roll;
    rst_n        <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      beat.operation = dir_rows[i].op;
      beat.car_id    = dir_rows[i].id;
      beat.car_dest  = dir_rows[i].dest;
      send_beat(beat, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      quiet = (n >= 250 && n < 320);
      if (n == 200) wait_drained();
      // Every so often the queue is filled past its depth to reach the full case.
      if (n % 80 == 40) begin
        repeat (DEPTH + 2) begin
          beat.operation = kfq_pkg::OP_APPEND;
          beat.car_id    = pick_id(kfq_pkg::OP_APPEND);
          beat.car_dest  = 8'($urandom);
          send_beat(beat, 1'b0, '0);
        end
      end
      roll = $urandom_range(99);
      if (roll < 40)      beat.operation = kfq_pkg::OP_APPEND;
      else if (roll < 65) beat.operation = kfq_pkg::OP_FIND;
      else if (roll < 92) beat.operation = kfq_pkg::OP_REMOVE;
      else                beat.operation = kfq_pkg::OP_CLEAR;
      beat.car_id   = pick_id(beat.operation);
      beat.car_dest = 8'($urandom);
      send_beat(beat, 1'b0, '0);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
